// File: hdl/hpl_pkg.sv
// ----------------------------------------------------------------------------
// hpl_pkg
// Shared types, constants and codes of the hashed prefix-length histogram.
// ----------------------------------------------------------------------------
package hpl_pkg;

  // Table geometry
  localparam int TABLE_BITS  = 10;
  localparam int AGE_BUCKETS = 100;
  localparam int NSLOTS      = 1 << TABLE_BITS;
  localparam int V4_LENS     = 33;
  localparam int V6_LENS     = 129;
  localparam int V4_DEPTH    = NSLOTS * V4_LENS;
  localparam int V6_DEPTH    = NSLOTS * V6_LENS;
  localparam int SLOT_AW     = TABLE_BITS;
  localparam int V4_AW       = $clog2(V4_DEPTH);
  localparam int V6_AW       = $clog2(V6_DEPTH);
  localparam int AGE_AW      = $clog2(AGE_BUCKETS);

  // Hash constants
  localparam logic [31:0] MIX_C1    = 32'h85ebca6b;
  localparam logic [31:0] MIX_C2    = 32'hc2b2ae35;
  localparam logic [31:0] HASH_MASK = 32'h00FFFFFF;

  // One day is 675 << 7 seconds: shift off the power of two, then
  // multiply by a truncated reciprocal of 675 and correct once.
  localparam int          DAY_SHIFT = 7;
  localparam int          DAY_ODD   = 675;
  localparam int          DAYN_W    = 32 - DAY_SHIFT;
  localparam logic [31:0] DAY_RECIP = 32'((64'd1 << 32) / DAY_ODD);

  // Length windows summed by a slot summary
  localparam int V4_LO  = 8;
  localparam int V4_HI  = 24;
  localparam int V6_LO  = 16;
  localparam int V6_HI  = 48;
  localparam int V4_MAX = 32;
  localparam int V6_MAX = 128;

  // Item operation codes
  localparam logic [2:0] FN_ADD4     = 3'd0;
  localparam logic [2:0] FN_ADD6     = 3'd1;
  localparam logic [2:0] FN_RD_AGE   = 3'd2;
  localparam logic [2:0] FN_RD_SLOT  = 3'd3;
  localparam logic [2:0] FN_RD_LEN   = 3'd4;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] asn;
    logic [7:0]  prefix_len;
    logic [31:0] stamp;
    logic [9:0]  index;
    logic        family_v6;
  } req_t;

  typedef struct packed {
    logic        occupied;
    logic [31:0] slot_asn;
    logic [31:0] count;
    logic [63:0] v4_total;
    logic [63:0] v6_total;
    logic        error;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_step;
    logic load;
    logic mix1;
    logic mix2;
    logic mix3;
    logic rd;
    logic upd;
    logic walk_step;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic item_err;
    logic is_add;
    logic is_walk;
    logic walk_last;
    logic out_free;
  } stat_t;

endpackage

// File: hdl/hpl_req_if.sv
// ----------------------------------------------------------------------------
// hpl_req_if
// Valid/ready channel carrying one route record or read request.
// ----------------------------------------------------------------------------
interface hpl_req_if import hpl_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/hpl_rsp_if.sv
// ----------------------------------------------------------------------------
// hpl_rsp_if
// Valid/ready channel carrying one result.
// ----------------------------------------------------------------------------
interface hpl_rsp_if import hpl_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/hpl_ctrl.sv
// ----------------------------------------------------------------------------
// hpl_ctrl
// Sequencer: clearing pass, then one item at a time through hash, read,
// update or summary walk, and result hand-off.
// ----------------------------------------------------------------------------
module hpl_ctrl import hpl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_MIX1   = 4'd3;
  localparam logic [3:0] S_MIX2   = 4'd4;
  localparam logic [3:0] S_MIX3   = 4'd5;
  localparam logic [3:0] S_READ   = 4'd6;
  localparam logic [3:0] S_UPDATE = 4'd7;
  localparam logic [3:0] S_WALK   = 4'd8;
  localparam logic [3:0] S_DRAIN  = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (stat.item_err) begin
          state_next = S_DONE;
        end else if (stat.is_add) begin
          state_next = S_MIX1;
        end else begin
          state_next = S_READ;
        end
      end
      S_MIX1: begin
        cmd.mix1   = 1'b1;
        state_next = S_MIX2;
      end
      S_MIX2: begin
        cmd.mix2   = 1'b1;
        state_next = S_MIX3;
      end
      S_MIX3: begin
        cmd.mix3   = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.rd = 1'b1;
        priority if (stat.is_add) begin
          state_next = S_UPDATE;
        end else if (stat.is_walk) begin
          state_next = S_WALK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_UPDATE: begin
        cmd.upd    = 1'b1;
        state_next = S_DONE;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/hpl_dpath.sv
// ----------------------------------------------------------------------------
// hpl_dpath
// Datapath: item latch, slot hash, day divider, the four stores, summary
// accumulators and the result register.
// ----------------------------------------------------------------------------
module hpl_dpath import hpl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  req_t        req_data,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp_data
);

  typedef struct packed {
    logic        used;
    logic [31:0] owner;
  } slot_ent_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Stores
  slot_ent_t   slot_mem [NSLOTS];
  logic [31:0] v4_mem   [V4_DEPTH];
  logic [31:0] v6_mem   [V6_DEPTH];
  logic [31:0] age_mem  [AGE_BUCKETS];

  logic [31:0]       now_seconds;
  req_t              item;
  logic [DAYN_W-1:0] day_n;
  logic [DAYN_W+31:0] day_prod;
  logic [AGE_AW-1:0] age_idx;
  logic [31:0]       p1;
  logic [31:0]       p2;
  logic [SLOT_AW-1:0] slot_h;
  logic [V6_AW-1:0]  clr_addr;
  logic [5:0]        wj;
  logic              acc4_en;
  logic              acc6_en;
  logic [5:0]        acc_len;
  logic [63:0]       acc4;
  logic [63:0]       acc6;
  slot_ent_t         slot_q;
  logic [31:0]       v4_q;
  logic [31:0]       v6_q;
  logic [31:0]       age_q;

  logic              is_add;
  logic              item_err;
  logic [31:0]       age_diff;
  logic [31:0]       x1;
  logic [31:0]       x2;
  logic [31:0]       h;
  logic [DAYN_W-1:0] q0;
  logic [DAYN_W-1:0] rem;
  logic [DAYN_W-1:0] qc;
  logic [SLOT_AW-1:0] slot_sel;
  logic [AGE_AW-1:0] age_sel;
  logic [7:0]        addr_len;
  logic [V4_AW-1:0]  v4_addr;
  logic [V6_AW-1:0]  v6_addr;
  logic              rd_age;
  logic              rd4;
  logic              rd6;
  logic              slot_we;
  logic [SLOT_AW-1:0] slot_wa;
  slot_ent_t         slot_wd;
  logic              v4_we;
  logic [V4_AW-1:0]  v4_wa;
  logic [31:0]       v4_wd;
  logic              v6_we;
  logic [V6_AW-1:0]  v6_wa;
  logic [31:0]       v6_wd;
  logic              age_we;
  logic [AGE_AW-1:0] age_wa;
  logic [31:0]       age_wd;
  logic [6:0]        sh4;
  logic [6:0]        sh6;
  logic [64:0]       sum4;
  logic [95:0]       term6;
  logic [64:0]       sum6;
  rsp_t              rsp_d;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      now_seconds <= '0;
    end else if (cfg_wr_en) begin
      now_seconds <= cfg_wr_data;
    end
  end

  // Item checks
  assign is_add = (item.func == FN_ADD4) || (item.func == FN_ADD6);

  always_comb begin
    unique case (item.func)
      FN_ADD4:    item_err = 32'(item.prefix_len) > V4_MAX;
      FN_ADD6:    item_err = 32'(item.prefix_len) > V6_MAX;
      FN_RD_AGE:  item_err = 32'(item.index) >= AGE_BUCKETS;
      FN_RD_SLOT: item_err = 32'(item.index) >= NSLOTS;
      FN_RD_LEN:  item_err = (32'(item.index) >= NSLOTS) ||
                             (32'(item.prefix_len) > (item.family_v6 ? V6_MAX : V4_MAX));
      default:    item_err = 1'b1;
    endcase
  end

  // Latch the item and its age in units of 1 << DAY_SHIFT seconds; clear the walk
  assign age_diff = (req_data.stamp > now_seconds) ? '0 : now_seconds - req_data.stamp;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item  <= req_data;
      day_n <= age_diff[31:DAY_SHIFT];
    end
  end

  // Hash and day division over stages mix1 to mix3; the divider ends in mix2
  assign x1  = item.asn ^ (item.asn >> 16);
  assign x2  = p1 ^ (p1 >> 13);
  assign h   = (p2 ^ (p2 >> 16)) & HASH_MASK;
  assign q0  = day_prod[DAYN_W+31:32];
  assign rem = day_n - DAYN_W'(q0 * DAYN_W'(DAY_ODD));
  assign qc  = (32'(rem) >= DAY_ODD) ? q0 + DAYN_W'(1) : q0;

  always_ff @(posedge clk) begin
    if (cmd.mix1) begin
      p1       <= x1 * MIX_C1;
      day_prod <= (DAYN_W+32)'(day_n) * (DAYN_W+32)'(DAY_RECIP);
    end
    if (cmd.mix2) begin
      p2      <= x2 * MIX_C2;
      age_idx <= (32'(qc) > AGE_BUCKETS - 1) ? AGE_AW'(AGE_BUCKETS - 1) : AGE_AW'(qc);
    end
    if (cmd.mix3) begin
      slot_h <= h[SLOT_AW-1:0];
    end
  end

  // Addresses
  assign slot_sel = is_add ? slot_h : SLOT_AW'(item.index);
  assign age_sel  = is_add ? age_idx : AGE_AW'(item.index);
  assign addr_len = cmd.walk_step ? 8'(wj) : item.prefix_len;
  assign v4_addr  = V4_AW'(slot_sel) * V4_AW'(V4_LENS) + V4_AW'(addr_len);
  assign v6_addr  = V6_AW'(slot_sel) * V6_AW'(V6_LENS) + V6_AW'(addr_len);

  assign rd_age = cmd.rd && (is_add || item.func == FN_RD_AGE);
  assign rd4 = (cmd.rd && (item.func == FN_ADD4 ||
                           (item.func == FN_RD_LEN && !item.family_v6))) ||
               (cmd.walk_step && 32'(wj) <= V4_HI);
  assign rd6 = (cmd.rd && (item.func == FN_ADD6 ||
                           (item.func == FN_RD_LEN && item.family_v6))) ||
               (cmd.walk_step && 32'(wj) >= V6_LO);

  // Write ports: clearing pass or record update
  always_comb begin
    slot_we = 1'b0;
    slot_wa = slot_h;
    slot_wd = slot_q.used ? slot_q : slot_ent_t'({1'b1, item.asn});
    v4_we   = 1'b0;
    v4_wa   = v4_addr;
    v4_wd   = sat_inc(v4_q);
    v6_we   = 1'b0;
    v6_wa   = v6_addr;
    v6_wd   = sat_inc(v6_q);
    age_we  = 1'b0;
    age_wa  = age_idx;
    age_wd  = sat_inc(age_q);
    priority if (cmd.clr_step) begin
      slot_we = 32'(clr_addr) < NSLOTS;
      slot_wa = SLOT_AW'(clr_addr);
      slot_wd = '0;
      v4_we   = 32'(clr_addr) < V4_DEPTH;
      v4_wa   = V4_AW'(clr_addr);
      v4_wd   = '0;
      v6_we   = 1'b1;
      v6_wa   = clr_addr;
      v6_wd   = '0;
      age_we  = 32'(clr_addr) < AGE_BUCKETS;
      age_wa  = AGE_AW'(clr_addr);
      age_wd  = '0;
    end else if (cmd.upd) begin
      slot_we = 1'b1;
      v4_we   = item.func == FN_ADD4;
      v6_we   = item.func == FN_ADD6;
      age_we  = 1'b1;
    end
  end

  // Clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + V6_AW'(1);
    end
  end

  // Memories, registered read
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (cmd.rd) begin
      slot_q <= slot_mem[slot_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (v4_we) begin
      v4_mem[v4_wa] <= v4_wd;
    end
    if (rd4) begin
      v4_q <= v4_mem[v4_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (v6_we) begin
      v6_mem[v6_wa] <= v6_wd;
    end
    if (rd6) begin
      v6_q <= v6_mem[v6_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (age_we) begin
      age_mem[age_wa] <= age_wd;
    end
    if (rd_age) begin
      age_q <= age_mem[age_sel];
    end
  end

  // Summary walk: issue a length a cycle, accumulate it in the next cycle
  assign sh4   = 7'(32) - 7'(acc_len);
  assign sh6   = 7'(64) - 7'(acc_len);
  assign sum4  = 65'(acc4) + 65'(64'(v4_q) << sh4);
  assign term6 = 96'(v6_q) << sh6;
  assign sum6  = 65'(acc6) + 65'(term6[63:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc4_en <= 1'b0;
      acc6_en <= 1'b0;
    end else begin
      acc4_en <= cmd.walk_step && 32'(wj) <= V4_HI;
      acc6_en <= cmd.walk_step && 32'(wj) >= V6_LO;
    end
  end

  always_ff @(posedge clk) begin
    acc_len <= wj;
    if (cmd.load) begin
      wj   <= 6'(V4_LO);
      acc4 <= '0;
      acc6 <= '0;
    end else begin
      if (cmd.walk_step) begin
        wj <= wj + 6'd1;
      end
      if (acc4_en) begin
        acc4 <= sum4[64] ? '1 : sum4[63:0];
      end
      if (acc6_en) begin
        acc6 <= (sum6[64] || term6[95:64] != '0) ? '1 : sum6[63:0];
      end
    end
  end

  // Assemble the result
  always_comb begin
    rsp_d = '0;
    if (item_err) begin
      rsp_d.error = 1'b1;
    end else begin
      unique case (item.func)
        FN_ADD4, FN_ADD6: begin
          rsp_d.occupied = 1'b1;
          rsp_d.slot_asn = slot_q.used ? slot_q.owner : item.asn;
          rsp_d.count    = (item.func == FN_ADD4) ? sat_inc(v4_q) : sat_inc(v6_q);
        end
        FN_RD_AGE: begin
          rsp_d.count = age_q;
        end
        FN_RD_SLOT: begin
          rsp_d.occupied = slot_q.used;
          rsp_d.slot_asn = slot_q.owner;
          rsp_d.v4_total = acc4;
          rsp_d.v6_total = acc6;
        end
        FN_RD_LEN: begin
          rsp_d.occupied = slot_q.used;
          rsp_d.slot_asn = slot_q.owner;
          rsp_d.count    = item.family_v6 ? v6_q : v4_q;
        end
        default: begin
          rsp_d.error = 1'b1;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp_data <= rsp_d;
    end
  end

  // Status
  assign stat.clr_last  = 32'(clr_addr) == V6_DEPTH - 1;
  assign stat.item_err  = item_err;
  assign stat.is_add    = is_add;
  assign stat.is_walk   = item.func == FN_RD_SLOT;
  assign stat.walk_last = 32'(wj) == V6_HI;
  assign stat.out_free  = !rsp_valid || rsp_ready;

endmodule

// File: hdl/hashed_prefix_length_histogram.sv
// ----------------------------------------------------------------------------
// hashed_prefix_length_histogram
// Per-AS prefix-length histogram over a hashed slot table, with age buckets.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    func, asn, prefix_len, stamp, index, family_v6
//   rsp      out  valid/ready    occupied, slot_asn, count, v4/v6 totals, error
//   cfg      in   cfg_wr_en      now_seconds (cfg_wr_data)
//
// One item at a time. Add: hash and day divide run in stages MIX1 to MIX3,
// then read and write-back of the counter. Age or length read: decode, read
// and result. Slot summary: one counter a cycle from lengths 8 to 48. Bad
// items go from decode straight to the result. After reset a clearing pass
// (one entry a cycle over the largest store) runs before req is ready.
// A result waits in the output register while rsp stalls.
// ----------------------------------------------------------------------------
module hashed_prefix_length_histogram import hpl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  hpl_req_if.sink     req,
  hpl_rsp_if.source   rsp,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer
  hpl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath and stores
  hpl_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .req_data    (req.data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_data    (rsp.data)
  );

endmodule
